FILE: src/vcfc_pkg.sv
// Shared constants, types and step codes for the voxel chunk face culling block.
package vcfc_pkg;

	// chunk geometry
	localparam int unsigned CHUNK_EDGE  = 16;
	localparam int unsigned VOXEL_COUNT = CHUNK_EDGE * CHUNK_EDGE * CHUNK_EDGE;
	localparam int unsigned ADDR_W      = $clog2(VOXEL_COUNT);

	// neighbor coordinate width: holds -1 (as wrap) and CHUNK_EDGE itself
	localparam int unsigned NB_W    = 7;
	localparam int unsigned COORD_W = 4;
	localparam int unsigned ID_W    = 4;

	// action codes
	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	// block IDs with atlas tiles
	localparam logic [ID_W-1:0] STONE_ID  = 4'd2;
	localparam logic [ID_W-1:0] DIRT_ID   = 4'd3;
	localparam logic [4:0]      STONE_COL = 5'd19;
	localparam logic [3:0]      STONE_ROW = 4'd15;
	localparam logic [4:0]      DIRT_COL  = 5'd18;
	localparam logic [3:0]      DIRT_ROW  = 4'd14;

	localparam logic [15:0] OPAQUE_RESET = 16'd12;

	// read sequence: the voxel itself, then faces in mask bit order
	typedef enum logic [2:0] {
		STEP_CENTER = 3'd0,
		STEP_PZ     = 3'd1,
		STEP_NZ     = 3'd2,
		STEP_PY     = 3'd3,
		STEP_NY     = 3'd4,
		STEP_PX     = 3'd5,
		STEP_NX     = 3'd6
	} vcfc_step_t;

	// address unit result
	typedef struct packed {
		logic              in_chunk;
		logic [ADDR_W-1:0] addr;
	} vcfc_addr_t;

endpackage

FILE: src/vcfc_ram.sv
// Generic single-port RAM with registered read.
module vcfc_ram #(
	parameter int unsigned WIDTH = 4,
	parameter int unsigned DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

FILE: src/vcfc_addr_unit.sv
// Shared neighbor address unit: offsets a voxel by one step, checks the border, forms the index.
module vcfc_addr_unit (
	input  logic [vcfc_pkg::COORD_W-1:0] x,
	input  logic [vcfc_pkg::COORD_W-1:0] y,
	input  logic [vcfc_pkg::COORD_W-1:0] z,
	input  vcfc_pkg::vcfc_step_t         step,
	output vcfc_pkg::vcfc_addr_t         res
);

	localparam int unsigned IW = vcfc_pkg::ADDR_W + 2 * vcfc_pkg::NB_W;
	localparam logic [vcfc_pkg::NB_W-1:0] EDGE = vcfc_pkg::NB_W'(vcfc_pkg::CHUNK_EDGE);

	logic [vcfc_pkg::NB_W-1:0] nx, ny, nz;
	logic [vcfc_pkg::NB_W-1:0] bx, by, bz;
	logic [IW-1:0]             idx;

	assign bx = vcfc_pkg::NB_W'(x);
	assign by = vcfc_pkg::NB_W'(y);
	assign bz = vcfc_pkg::NB_W'(z);

	// step offset; minus one wraps high and so lands outside the chunk
	always_comb begin
		nx = bx;
		ny = by;
		nz = bz;
		case (step)
			vcfc_pkg::STEP_PZ: nz = bz + 1'b1;
			vcfc_pkg::STEP_NZ: nz = bz - 1'b1;
			vcfc_pkg::STEP_PY: ny = by + 1'b1;
			vcfc_pkg::STEP_NY: ny = by - 1'b1;
			vcfc_pkg::STEP_PX: nx = bx + 1'b1;
			vcfc_pkg::STEP_NX: nx = bx - 1'b1;
			default: ;
		endcase
	end

	// index x*E*E + y*E + z, constant multipliers only
	assign idx = IW'(nx) * IW'(vcfc_pkg::CHUNK_EDGE * vcfc_pkg::CHUNK_EDGE)
		+ IW'(ny) * IW'(vcfc_pkg::CHUNK_EDGE) + IW'(nz);

	assign res.in_chunk = (nx < EDGE) && (ny < EDGE) && (nz < EDGE);
	assign res.addr     = idx[vcfc_pkg::ADDR_W-1:0];

endmodule

FILE: src/voxel_chunk_face_culling.sv
// Top level: chunk store, read sequencer and face mask assembly.
//
// Voxel chunk face culling. Block IDs live in one single-port RAM of CHUNK_EDGE^3
// four-bit entries. A write beat is accepted in IDLE and the RAM write follows in
// the WRITE state. A query reads the voxel and its six neighbors through the one
// RAM port, one read per cycle in the READ state; the last read data is collected
// in DRAIN and the result register is loaded in FINISH, later if the previous
// result has not been taken. in_ready is low while an item is in work. The store
// has no reset: query only voxels of a fully loaded chunk. The opacity table
// opaque_q is written through cfg_we and cfg_wdata; the user must write it only
// while the block is idle, which the block does not enforce. Reset leaves IDs 2
// and 3 opaque.
module voxel_chunk_face_culling (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [15:0]                  cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         action,
	input  logic [vcfc_pkg::COORD_W-1:0] voxel_x,
	input  logic [vcfc_pkg::COORD_W-1:0] voxel_y,
	input  logic [vcfc_pkg::COORD_W-1:0] voxel_z,
	input  logic [vcfc_pkg::ID_W-1:0]    block_id,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [5:0]                   face_mask,
	output logic [2:0]                   face_count,
	output logic [4:0]                   tile_col,
	output logic [3:0]                   tile_row
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WRITE,
		ST_READ,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	state_t                       state_q;
	vcfc_pkg::vcfc_step_t         step_q;
	vcfc_pkg::vcfc_step_t         rd_step_s1;
	logic                         rd_vld_s1;
	logic                         rd_in_s1;
	logic [vcfc_pkg::COORD_W-1:0] x_q, y_q, z_q;
	logic [vcfc_pkg::ID_W-1:0]    id_q;
	logic [vcfc_pkg::ID_W-1:0]    here_q;
	logic                         center_in_q;
	logic [5:0]                   mask_q;
	logic [15:0]                  opaque_q;
	logic                         out_valid_q;
	logic [5:0]                   face_mask_q;
	logic [2:0]                   face_count_q;
	logic [4:0]                   tile_col_q;
	logic [3:0]                   tile_row_q;

	vcfc_pkg::vcfc_step_t         au_step;
	vcfc_pkg::vcfc_addr_t         au_res;
	logic                         ram_en;
	logic                         ram_we;
	logic [vcfc_pkg::ID_W-1:0]    ram_rdata;
	logic [5:0]                   fin_mask;
	logic [2:0]                   fin_count;
	logic [2:0]                   bit_idx;

	// opacity table register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			opaque_q <= vcfc_pkg::OPAQUE_RESET;
		end else if (cfg_we) begin
			opaque_q <= cfg_wdata;
		end
	end

	// shared address unit
	assign au_step = (state_q == ST_READ) ? step_q : vcfc_pkg::STEP_CENTER;

	vcfc_addr_unit u_addr (
		.x    (x_q),
		.y    (y_q),
		.z    (z_q),
		.step (au_step),
		.res  (au_res)
	);

	// chunk store
	assign ram_we = (state_q == ST_WRITE);
	assign ram_en = au_res.in_chunk && ((state_q == ST_WRITE) || (state_q == ST_READ));

	vcfc_ram #(
		.WIDTH (vcfc_pkg::ID_W),
		.DEPTH (vcfc_pkg::VOXEL_COUNT)
	) u_ram (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (au_res.addr),
		.wdata (id_q),
		.rdata (ram_rdata)
	);

	// final mask and count
	assign fin_mask  = (center_in_q && opaque_q[here_q]) ? mask_q : 6'd0;
	assign fin_count = 3'(fin_mask[0]) + 3'(fin_mask[1]) + 3'(fin_mask[2])
		+ 3'(fin_mask[3]) + 3'(fin_mask[4]) + 3'(fin_mask[5]);
	assign bit_idx   = 3'(rd_step_s1) - 3'd1;

	// sequencer, read data collection and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= vcfc_pkg::STEP_CENTER;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_s1  <= (state_q == ST_READ);
			rd_step_s1 <= step_q;
			rd_in_s1   <= au_res.in_chunk;

			// beat taken; in finish a new result replaces it instead
			if (out_valid_q && out_ready && (state_q != ST_FINISH)) begin
				out_valid_q <= 1'b0;
			end

			// collect read data in the cycle after each read
			if (rd_vld_s1) begin
				if (rd_step_s1 == vcfc_pkg::STEP_CENTER) begin
					here_q      <= rd_in_s1 ? ram_rdata : '0;
					center_in_q <= rd_in_s1;
				end else begin
					mask_q[bit_idx] <= !(rd_in_s1 && opaque_q[ram_rdata]);
				end
			end

			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						x_q  <= voxel_x;
						y_q  <= voxel_y;
						z_q  <= voxel_z;
						id_q <= block_id;
						step_q <= vcfc_pkg::STEP_CENTER;
						state_q <= (action == vcfc_pkg::ACT_QUERY) ? ST_READ : ST_WRITE;
					end
				end
				ST_WRITE: begin
					state_q <= ST_IDLE;
				end
				ST_READ: begin
					if (step_q == vcfc_pkg::STEP_NX) begin
						state_q <= ST_DRAIN;
					end else begin
						step_q <= vcfc_pkg::vcfc_step_t'(3'(step_q) + 3'd1);
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q  <= 1'b1;
						face_mask_q  <= fin_mask;
						face_count_q <= fin_count;
						if (here_q == vcfc_pkg::STONE_ID) begin
							tile_col_q <= vcfc_pkg::STONE_COL;
							tile_row_q <= vcfc_pkg::STONE_ROW;
						end else if (here_q == vcfc_pkg::DIRT_ID) begin
							tile_col_q <= vcfc_pkg::DIRT_COL;
							tile_row_q <= vcfc_pkg::DIRT_ROW;
						end else begin
							tile_col_q <= 5'd0;
							tile_row_q <= 4'd0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready   = (state_q == ST_IDLE);
	assign out_valid  = out_valid_q;
	assign face_mask  = face_mask_q;
	assign face_count = face_count_q;
	assign tile_col   = tile_col_q;
	assign tile_row   = tile_row_q;

	// count always matches the mask it goes with
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> face_count == 3'($countones(face_mask)))
		else $error("face_count does not match face_mask");

	// a write beat holds the port through the WRITE state, then in_ready returns
	a_write_two_cycles: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && action == vcfc_pkg::ACT_WRITE) |=> !in_ready ##1 in_ready)
		else $error("write did not complete in two cycles");

	// every neighbor read has landed before the result is assembled
	a_reads_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH) |-> !rd_vld_s1)
		else $error("read data still in flight at finish");

	// read sequence never runs past the last face
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |=> (state_q == ST_READ) || (state_q == ST_DRAIN))
		else $error("read sequence left early");

endmodule
